[hdl/assert_macros.svh]
// Assertion helpers for the frustum cull block.
// All checks sample on the rising clock edge and are off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic form: label, clock, active-low reset, property, message
`define FPCT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Short form on the block clock and reset
`define FPCT_ASSERT(lbl, prop, msg) `FPCT_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

[hdl/fpct_pkg.sv]
// ----------------------------------------------------------------------------
// fpct_pkg - frustum plane cull test package
// Widths, plane count and request codes shared by the cull test logic.
// ----------------------------------------------------------------------------
`default_nettype none

package fpct_pkg;

    // plane store and fixed-point format
    localparam int NUM_PLANES = 6;
    localparam int FRAC_BITS  = 16;

    // item field widths
    localparam int REQ_W = 2;
    localparam int IDX_W = 3;
    localparam int VAL_W = 32;
    localparam int EXT_W = 31;

    // stream widths
    localparam int TUSER_IN_W  = REQ_W + IDX_W;
    localparam int TDATA_IN_W  = ((4 * VAL_W + 3 * EXT_W + 7) / 8) * 8;
    localparam int TDATA_OUT_W = 8;

    // datapath widths
    localparam int PROD_W = 2 * VAL_W;          // signed normal * coordinate
    localparam int BPROD_W = VAL_W + EXT_W;     // |normal| * extent
    localparam int OFF_W  = VAL_W + 1;          // offset minus radius
    localparam int SUM_W  = PROD_W + 2;         // three products plus offset
    localparam int BSUM_W = BPROD_W + 2;        // three extent products
    localparam int CMP_W  = SUM_W + 1;          // final signed compare

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_SPHERE = 2'd1,
        REQ_BOX    = 2'd2
    } t_req;

endpackage

`default_nettype wire

[hdl/frustum_plane_cull_test.sv]
// ----------------------------------------------------------------------------
// frustum_plane_cull_test - six plane sphere / box frustum cull
// Holds the frustum planes and answers sphere and box visibility queries.
// ----------------------------------------------------------------------------
// Accepts one item per clock unless a stalled output has filled every stage. A
// load item writes its plane at the accept edge and returns nothing; a later
// query sees the new plane. A sphere or box query returns one result: the
// accept edge loads the input register, then the products (one multiplier per
// term and plane) are registered, then the per-plane sums, and last the compare
// goes into the result register. Every stage holds its own valid bit, so input is
// still taken while a result waits on the output as long as a stage is free.
// Planes reset to zero. All arithmetic is exact; nothing wraps or saturates.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module frustum_plane_cull_test (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // slave side
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // tdata: val_x, val_y, val_z, val_w, ext_x, ext_y, ext_z, zero fill
    input  wire logic [fpct_pkg::TDATA_IN_W-1:0]    i_s_axis_tdata,
    // tuser: req_type, plane_index
    input  wire logic [fpct_pkg::TUSER_IN_W-1:0]    i_s_axis_tuser,
    // master side
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // tdata: inside_res, zero fill
    output logic [fpct_pkg::TDATA_OUT_W-1:0]        o_m_axis_tdata
);

    localparam int NP = fpct_pkg::NUM_PLANES;
    localparam int VW = fpct_pkg::VAL_W;
    localparam int EW = fpct_pkg::EXT_W;

    // ------------------------------------------------------------------
    // Input field decode
    // ------------------------------------------------------------------
    fpct_pkg::t_req                  w_in_req;
    logic [fpct_pkg::IDX_W-1:0]      w_in_idx;
    logic signed [VW-1:0]            w_in_x, w_in_y, w_in_z, w_in_w;
    logic [EW-1:0]                   w_in_ex, w_in_ey, w_in_ez;
    logic                            w_in_acc;
    logic                            w_in_test;
    logic                            w_in_box;

    assign w_in_req = fpct_pkg::t_req'(i_s_axis_tuser[fpct_pkg::REQ_W-1:0]);
    assign w_in_idx = i_s_axis_tuser[fpct_pkg::TUSER_IN_W-1:fpct_pkg::REQ_W];
    assign w_in_x   = i_s_axis_tdata[0*VW +: VW];
    assign w_in_y   = i_s_axis_tdata[1*VW +: VW];
    assign w_in_z   = i_s_axis_tdata[2*VW +: VW];
    assign w_in_w   = i_s_axis_tdata[3*VW +: VW];
    assign w_in_ex  = i_s_axis_tdata[4*VW +: EW];
    assign w_in_ey  = i_s_axis_tdata[4*VW + EW +: EW];
    assign w_in_ez  = i_s_axis_tdata[4*VW + 2*EW +: EW];

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_box  = (w_in_req == fpct_pkg::REQ_BOX);
    assign w_in_test = (w_in_req == fpct_pkg::REQ_SPHERE) || w_in_box;

    // ------------------------------------------------------------------
    // Stage handshake: a stage moves when it is empty or the next one moves
    // ------------------------------------------------------------------
    logic r_v0, r_v1, r_v2, r_out_valid;
    logic w_rdy0, w_rdy1, w_rdy2, w_rdy3;

    assign w_rdy3 = !r_out_valid || i_m_axis_tready;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_rdy0 = !r_v0 || w_rdy1;

    assign o_s_axis_tready = w_rdy0;

    // ------------------------------------------------------------------
    // Plane store, written by load items at the accept edge
    // ------------------------------------------------------------------
    logic signed [VW-1:0] r_pn_x [NP];
    logic signed [VW-1:0] r_pn_y [NP];
    logic signed [VW-1:0] r_pn_z [NP];
    logic signed [VW-1:0] r_p_off [NP];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NP; i++) begin
            if (!i_rst_n) begin
                r_pn_x[i]  <= '0;
                r_pn_y[i]  <= '0;
                r_pn_z[i]  <= '0;
                r_p_off[i] <= '0;
            end else if (w_in_acc && (w_in_req == fpct_pkg::REQ_LOAD)
                         && (w_in_idx == fpct_pkg::IDX_W'(i))) begin
                r_pn_x[i]  <= w_in_x;
                r_pn_y[i]  <= w_in_y;
                r_pn_z[i]  <= w_in_z;
                r_p_off[i] <= w_in_w;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: query register. Radius only for spheres, extents only for boxes.
    // ------------------------------------------------------------------
    logic signed [VW-1:0] r0_x, r0_y, r0_z, r0_r;
    logic [EW-1:0]        r0_ex, r0_ey, r0_ez;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_rdy0) begin
            r_v0 <= w_in_acc && w_in_test;
        end
        if (w_rdy0) begin
            r0_x  <= w_in_x;
            r0_y  <= w_in_y;
            r0_z  <= w_in_z;
            r0_r  <= w_in_box ? '0 : w_in_w;
            r0_ex <= w_in_box ? w_in_ex : '0;
            r0_ey <= w_in_box ? w_in_ey : '0;
            r0_ez <= w_in_box ? w_in_ez : '0;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: per-plane products and offset minus radius
    // ------------------------------------------------------------------
    logic signed [fpct_pkg::PROD_W-1:0] r1_px [NP];
    logic signed [fpct_pkg::PROD_W-1:0] r1_py [NP];
    logic signed [fpct_pkg::PROD_W-1:0] r1_pz [NP];
    logic [fpct_pkg::BPROD_W-1:0]       r1_bx [NP];
    logic [fpct_pkg::BPROD_W-1:0]       r1_by [NP];
    logic [fpct_pkg::BPROD_W-1:0]       r1_bz [NP];
    logic signed [fpct_pkg::OFF_W-1:0]  r1_off [NP];

    // |normal| fits 32 bits unsigned, including the most negative code
    logic [VW-1:0] n_abs_x [NP];
    logic [VW-1:0] n_abs_y [NP];
    logic [VW-1:0] n_abs_z [NP];

    always_comb begin
        for (int i = 0; i < NP; i++) begin
            n_abs_x[i] = r_pn_x[i][VW-1] ? (~r_pn_x[i] + 1'b1) : r_pn_x[i];
            n_abs_y[i] = r_pn_y[i][VW-1] ? (~r_pn_y[i] + 1'b1) : r_pn_y[i];
            n_abs_z[i] = r_pn_z[i][VW-1] ? (~r_pn_z[i] + 1'b1) : r_pn_z[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= r_v0;
        end
        if (w_rdy1) begin
            for (int i = 0; i < NP; i++) begin
                r1_px[i]  <= fpct_pkg::PROD_W'(r_pn_x[i]) * fpct_pkg::PROD_W'(r0_x);
                r1_py[i]  <= fpct_pkg::PROD_W'(r_pn_y[i]) * fpct_pkg::PROD_W'(r0_y);
                r1_pz[i]  <= fpct_pkg::PROD_W'(r_pn_z[i]) * fpct_pkg::PROD_W'(r0_z);
                r1_bx[i]  <= fpct_pkg::BPROD_W'(n_abs_x[i]) * fpct_pkg::BPROD_W'(r0_ex);
                r1_by[i]  <= fpct_pkg::BPROD_W'(n_abs_y[i]) * fpct_pkg::BPROD_W'(r0_ey);
                r1_bz[i]  <= fpct_pkg::BPROD_W'(n_abs_z[i]) * fpct_pkg::BPROD_W'(r0_ez);
                r1_off[i] <= fpct_pkg::OFF_W'(r_p_off[i]) - fpct_pkg::OFF_W'(r0_r);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: plane distance sum and extent sum per plane
    // ------------------------------------------------------------------
    logic signed [fpct_pkg::SUM_W-1:0] r2_sp [NP];
    logic [fpct_pkg::BSUM_W-1:0]       r2_sb [NP];
    logic signed [fpct_pkg::SUM_W-1:0] n_sp [NP];
    logic [fpct_pkg::BSUM_W-1:0]       n_sb [NP];

    always_comb begin
        for (int i = 0; i < NP; i++) begin
            n_sp[i] = fpct_pkg::SUM_W'(r1_px[i]) + fpct_pkg::SUM_W'(r1_py[i])
                    + fpct_pkg::SUM_W'(r1_pz[i])
                    + (fpct_pkg::SUM_W'(r1_off[i]) <<< fpct_pkg::FRAC_BITS);
            n_sb[i] = fpct_pkg::BSUM_W'(r1_bx[i]) + fpct_pkg::BSUM_W'(r1_by[i])
                    + fpct_pkg::BSUM_W'(r1_bz[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
        if (w_rdy2) begin
            for (int i = 0; i < NP; i++) begin
                r2_sp[i] <= n_sp[i];
                r2_sb[i] <= n_sb[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: a plane culls when distance minus extent term is above zero
    // ------------------------------------------------------------------
    logic signed [fpct_pkg::CMP_W-1:0] n_diff [NP];
    logic [NP-1:0]                     n_cull;
    logic                              r_inside;

    always_comb begin
        for (int i = 0; i < NP; i++) begin
            n_diff[i] = fpct_pkg::CMP_W'(r2_sp[i])
                      - fpct_pkg::CMP_W'($signed({1'b0, r2_sb[i]}));
            n_cull[i] = !n_diff[i][fpct_pkg::CMP_W-1] && (n_diff[i] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rdy3) begin
            r_out_valid <= r_v2;
        end
        if (w_rdy3) begin
            r_inside <= ~|n_cull;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = fpct_pkg::TDATA_OUT_W'(r_inside);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `FPCT_ASSERT(a_load_no_entry, (w_in_acc && (w_in_req == fpct_pkg::REQ_LOAD)) |=> !r_v0, "load item entered the query pipe")
    `FPCT_ASSERT(a_test_enters, (w_in_acc && w_in_test) |=> r_v0, "accepted query missing from stage 0")
    `FPCT_ASSERT(a_full_stalls, (r_out_valid && !i_m_axis_tready && r_v2 && r_v1 && r_v0) |-> !o_s_axis_tready, "input ready while pipe is full and stalled")

endmodule

`default_nettype wire
